// File: rtl/hdc_pkg.sv
// Package for the holiday date calculator: widths, holiday codes, constants, helpers.
package hdc_pkg;

    localparam int OP_W    = 5;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_EASTER          = 5'd0,
        OP_ORTH_JULIAN     = 5'd1,
        OP_ORTH_GREG       = 5'd2,
        OP_NEW_YEAR        = 5'd3,
        OP_GOOD_FRIDAY     = 5'd4,
        OP_XMAS_EVE        = 5'd5,
        OP_XMAS            = 5'd6,
        OP_US_NEW_YEAR     = 5'd7,
        OP_MLK             = 5'd8,
        OP_PRESIDENTS      = 5'd9,
        OP_MEMORIAL        = 5'd10,
        OP_US_INDEP        = 5'd11,
        OP_LABOR           = 5'd12,
        OP_COLUMBUS        = 5'd13,
        OP_VETERANS        = 5'd14,
        OP_THANKSGIVING    = 5'd15,
        OP_US_XMAS         = 5'd16,
        OP_EASTER_MON      = 5'd17,
        OP_MAY_DAY         = 5'd18,
        OP_PENTECOST       = 5'd19,
        OP_PENTECOST_MON   = 5'd20,
        OP_ASCENSION       = 5'd21,
        OP_OCT_3           = 5'd22,
        OP_DEC_26          = 5'd23,
        OP_EPIPHANY        = 5'd24,
        OP_MAR_8           = 5'd25,
        OP_CORPUS_CHRISTI  = 5'd26,
        OP_AUG_15          = 5'd27,
        OP_SEP_20          = 5'd28,
        OP_OCT_31          = 5'd29,
        OP_NOV_1           = 5'd30,
        OP_NOV_22_WED      = 5'd31
    } op_t;

    // Weekday codes, Sunday first
    localparam logic [2:0] SUNDAY    = 3'd0;
    localparam logic [2:0] MONDAY    = 3'd1;
    localparam logic [2:0] WEDNESDAY = 3'd3;
    localparam logic [2:0] THURSDAY  = 3'd4;
    localparam logic [2:0] SATURDAY  = 3'd6;

    // Reciprocal multipliers for division by constants
    localparam logic [12:0] DIV100_MUL  = 13'd5243;   // y / 100, shift 19
    localparam logic [15:0] DIV19_MUL   = 16'd55189;  // y / 19, shift 20
    localparam logic [14:0] DIV7_MUL    = 15'd18725;  // y / 7, shift 17
    localparam logic [13:0] DIV100W_MUL = 14'd10486;  // biased year / 100, shift 20
    localparam logic [9:0]  DIV30_MUL   = 10'd547;    // h / 30, shift 14

    localparam logic [14:0] YEAR_BIAS = 15'd399;

    // Easter offsets in days, two's complement
    localparam logic [7:0] OFS_NONE      = 8'd0;
    localparam logic [7:0] OFS_GOOD_FRI  = 8'd254;  // -2
    localparam logic [7:0] OFS_EAS_MON   = 8'd1;
    localparam logic [7:0] OFS_ORTH      = 8'd13;
    localparam logic [7:0] OFS_ASCENSION = 8'd39;
    localparam logic [7:0] OFS_PENTECOST = 8'd49;
    localparam logic [7:0] OFS_PENT_MON  = 8'd50;
    localparam logic [7:0] OFS_CORPUS    = 8'd60;

    // Reduce a value below 128 modulo 7 (8 is 1 mod 7)
    function automatic logic [2:0] mod7_7(input logic [6:0] x);
        logic [3:0] s;
        logic [3:0] r;
        s = 4'(x[2:0]) + 4'(x[5:3]) + 4'(x[6]);
        if (s >= 4'd14)
            r = s - 4'd14;
        else if (s >= 4'd7)
            r = s - 4'd7;
        else
            r = s;
        return r[2:0];
    endfunction

    function automatic logic [2:0] mod7_15(input logic [14:0] x);
        logic [5:0] s;
        s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
        return mod7_7(7'(s));
    endfunction

    // Julian epact: (19 * a + 15) mod 30 for a = year mod 19
    function automatic logic [4:0] julian_epact(input logic [4:0] a);
        logic [4:0] r;
        case (a)
            5'd0:    r = 5'd15;
            5'd1:    r = 5'd4;
            5'd2:    r = 5'd23;
            5'd3:    r = 5'd12;
            5'd4:    r = 5'd1;
            5'd5:    r = 5'd20;
            5'd6:    r = 5'd9;
            5'd7:    r = 5'd28;
            5'd8:    r = 5'd17;
            5'd9:    r = 5'd6;
            5'd10:   r = 5'd25;
            5'd11:   r = 5'd14;
            5'd12:   r = 5'd3;
            5'd13:   r = 5'd22;
            5'd14:   r = 5'd11;
            5'd15:   r = 5'd0;
            5'd16:   r = 5'd19;
            5'd17:   r = 5'd8;
            5'd18:   r = 5'd27;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/holiday_date_calculator.sv
// Holiday date calculator: eight-stage pipeline from year and holiday code to a date.
//
// Query channel: operation (holiday code) and year_in, with query_valid and
// query_stall. Result channel: year_out, month_out, day_out, with result_valid
// and result_stall. Every query yields exactly one result, in order.
// The block is a pipeline of eight register stages, the last one being the
// output register. A query accepted at a clock edge passes stages one to seven
// and shows its result in the output register with result_valid high; one query
// can enter each cycle: throughput is one result per clock while results are taken.
// Easter dates walk through the computus over stages one to seven; fixed and
// weekday-rule dates are settled in stage four and ride along.
// When result_stall is high, the output holds; stages behind it keep filling
// empty slots and stall only once full, and query_stall rises when the first
// stage cannot move. No transaction is dropped or duplicated.
// Reset clears all valid bits; the pipeline is empty and ready right after it.
module holiday_date_calculator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        query_valid,
    output logic                        query_stall,
    input  logic [hdc_pkg::OP_W-1:0]    operation,
    input  logic [hdc_pkg::YEAR_W-1:0]  year_in,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [hdc_pkg::YEAR_W-1:0]  year_out,
    output logic [hdc_pkg::MONTH_W-1:0] month_out,
    output logic [hdc_pkg::DAY_W-1:0]   day_out
);
    import hdc_pkg::*;

    logic [7:0] vld_reg;
    logic [7:0] vld_next;
    logic [7:0] en;

    // Stage 1: quotients
    op_t               s1_op_reg,   s1_op_next;
    logic [YEAR_W-1:0] s1_y_reg,    s1_y_next;
    logic [7:0]        s1_b_reg,    s1_b_next;
    logic [9:0]        s1_q19_reg,  s1_q19_next;
    logic [11:0]       s1_q7_reg,   s1_q7_next;
    logic [7:0]        s1_qyy_reg,  s1_qyy_next;
    logic [26:0]       b_prod;
    logic [29:0]       q19_prod;
    logic [28:0]       q7_prod;
    logic [14:0]       yy_in;
    logic [28:0]       qyy_prod;

    // Stage 2: remainders, f, weekday sum
    op_t               s2_op_reg;
    logic [YEAR_W-1:0] s2_y_reg;
    logic [7:0]        s2_b_reg;
    logic [4:0]        s2_a19_reg,  s2_a19_next;
    logic [6:0]        s2_c_reg,    s2_c_next;
    logic [2:0]        s2_a7_reg,   s2_a7_next;
    logic [2:0]        s2_f_reg,    s2_f_next;
    logic [14:0]       s2_s_reg,    s2_s_next;
    logic [13:0]       a19_diff, c_diff, a7_diff, f_prod;
    logic [14:0]       yy_s2;

    // Stage 3: g, Julian epact, weekday of Jan 1, leap year
    op_t               s3_op_reg;
    logic [YEAR_W-1:0] s3_y_reg;
    logic [7:0]        s3_b_reg;
    logic [4:0]        s3_a19_reg;
    logic [6:0]        s3_c_reg;
    logic [2:0]        s3_a7_reg;
    logic [5:0]        s3_g_reg,    s3_g_next;
    logic [4:0]        s3_jd_reg,   s3_jd_next;
    logic [2:0]        s3_wd1_reg,  s3_wd1_next;
    logic              s3_leap_reg, s3_leap_next;
    logic [15:0]       g_prod;

    // Stage 4: h sum, Julian Easter index, fixed-date result
    op_t               s4_op_reg;
    logic [YEAR_W-1:0] s4_fy_reg,   s4_fy_next;
    logic [3:0]        s4_fm_reg,   s4_fm_next;
    logic [4:0]        s4_fd_reg,   s4_fd_next;
    logic [9:0]        s4_hsum_reg, s4_hsum_next;
    logic [6:0]        s4_idxj_reg, s4_idxj_next;
    logic [4:0]        s4_a19_reg;
    logic [6:0]        s4_c_reg;
    logic [1:0]        s4_e_reg;
    logic [2:0]        ej;
    logic [2:0]        wk_ofs;
    logic              use_leap;
    logic [2:0]        w;
    logic [2:0]        to_mon;
    logic [2:0]        to_thu;
    logic [2:0]        from_mon;
    logic [2:0]        from_wed;

    // Stage 5: h
    op_t               s5_op_reg;
    logic [YEAR_W-1:0] s5_fy_reg;
    logic [3:0]        s5_fm_reg;
    logic [4:0]        s5_fd_reg;
    logic [6:0]        s5_idxj_reg;
    logic [4:0]        s5_a19_reg;
    logic [4:0]        s5_h_reg,    s5_h_next;
    logic [4:0]        s5_i_reg;
    logic [1:0]        s5_k_reg;
    logic [1:0]        s5_e_reg;
    logic [18:0]       h_prod;
    logic [9:0]        h_diff;

    // Stage 6: l
    op_t               s6_op_reg;
    logic [YEAR_W-1:0] s6_fy_reg;
    logic [3:0]        s6_fm_reg;
    logic [4:0]        s6_fd_reg;
    logic [6:0]        s6_idxj_reg;
    logic [4:0]        s6_a19_reg;
    logic [4:0]        s6_h_reg;
    logic [2:0]        s6_l_reg,    s6_l_next;

    // Stage 7: day index from March 1 with offset applied
    logic              s7_eas_reg,  s7_eas_next;
    logic [YEAR_W-1:0] s7_fy_reg;
    logic [3:0]        s7_fm_reg;
    logic [4:0]        s7_fd_reg;
    logic [6:0]        s7_idx_reg,  s7_idx_next;
    logic [8:0]        m_sum;
    logic [6:0]        idx_g;
    logic [6:0]        idx_base;
    logic [7:0]        ofs;
    logic [7:0]        idx_sum;

    // Stage 8: output register
    logic [YEAR_W-1:0]  year_out_reg,  year_out_next;
    logic [MONTH_W-1:0] month_out_reg, month_out_next;
    logic [DAY_W-1:0]   day_out_reg,   day_out_next;

    // Handshake: a stage moves when it is empty or the next stage moves
    always_comb
    begin
        en[7] = !vld_reg[7] || !result_stall;
        for (int k = 6; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? query_valid : vld_reg[0];
        for (int k = 1; k < 8; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign query_stall  = !en[0];
    assign result_valid = vld_reg[7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Stage 1
    always_comb
    begin
        s1_op_next  = op_t'(operation);
        s1_y_next   = year_in;
        b_prod      = 27'(year_in) * 27'(DIV100_MUL);
        q19_prod    = 30'(year_in) * 30'(DIV19_MUL);
        q7_prod     = 29'(year_in) * 29'(DIV7_MUL);
        yy_in       = 15'(year_in) + YEAR_BIAS;
        qyy_prod    = 29'(yy_in) * 29'(DIV100W_MUL);
        s1_b_next   = b_prod[26:19];
        s1_q19_next = q19_prod[29:20];
        s1_q7_next  = q7_prod[28:17];
        s1_qyy_next = qyy_prod[27:20];
    end

    // Stage 2
    always_comb
    begin
        a19_diff    = s1_y_reg - 14'(s1_q19_reg) * 14'd19;
        c_diff      = s1_y_reg - 14'(s1_b_reg) * 14'd100;
        a7_diff     = s1_y_reg - 14'(s1_q7_reg) * 14'd7;
        f_prod      = (14'(s1_b_reg) + 14'd8) * 14'd41;
        yy_s2       = 15'(s1_y_reg) + YEAR_BIAS;
        s2_a19_next = a19_diff[4:0];
        s2_c_next   = c_diff[6:0];
        s2_a7_next  = a7_diff[2:0];
        s2_f_next   = f_prod[12:10];
        // days mod 7 of Jan 1: yy + yy/4 - yy/100 + yy/400 + 1
        s2_s_next   = yy_s2 + (yy_s2 >> 2) - 15'(s1_qyy_reg) + 15'(s1_qyy_reg >> 2) + 15'd1;
    end

    // Stage 3
    always_comb
    begin
        g_prod       = (16'(s2_b_reg) - 16'(s2_f_reg) + 16'd1) * 16'd171;
        s3_g_next    = g_prod[14:9];
        s3_jd_next   = julian_epact(s2_a19_reg);
        s3_wd1_next  = mod7_15(s2_s_reg);
        s3_leap_next = (s2_y_reg[1:0] == 2'd0)
                       && ((s2_c_reg != 7'd0) || (s2_b_reg[1:0] == 2'd0));
    end

    // Stage 4
    always_comb
    begin
        s4_hsum_next = 10'(s3_a19_reg) * 10'd19 + 10'(s3_b_reg) - 10'(s3_b_reg >> 2)
                       - 10'(s3_g_reg) + 10'd15;
        ej = mod7_7(7'(s3_y_reg[1:0]) * 7'd2 + 7'(s3_a7_reg) * 7'd4
                    - 7'(s3_jd_reg) + 7'd34);
        s4_idxj_next = 7'(s3_jd_reg) + 7'(ej) + 7'd21;

        // weekday of the rule's anchor date, relative to Jan 1
        unique case (s3_op_reg)
            OP_PRESIDENTS:   begin wk_ofs = 3'd3; use_leap = 1'b0; end
            OP_MEMORIAL:     begin wk_ofs = 3'd3; use_leap = 1'b1; end
            OP_US_INDEP:     begin wk_ofs = 3'd2; use_leap = 1'b1; end
            OP_LABOR:        begin wk_ofs = 3'd5; use_leap = 1'b1; end
            OP_COLUMBUS:     begin wk_ofs = 3'd0; use_leap = 1'b1; end
            OP_VETERANS:     begin wk_ofs = 3'd6; use_leap = 1'b1; end
            OP_THANKSGIVING: begin wk_ofs = 3'd3; use_leap = 1'b1; end
            OP_US_XMAS:      begin wk_ofs = 3'd1; use_leap = 1'b1; end
            OP_NOV_22_WED:   begin wk_ofs = 3'd3; use_leap = 1'b1; end
            default:         begin wk_ofs = 3'd0; use_leap = 1'b0; end
        endcase
        w        = mod7_7(7'(s3_wd1_reg) + 7'(wk_ofs) + 7'(use_leap & s3_leap_reg));
        to_mon   = mod7_7(7'(MONDAY) + 7'd7 - 7'(w));
        to_thu   = mod7_7(7'(THURSDAY) + 7'd7 - 7'(w));
        from_mon = mod7_7(7'(w) + 7'd7 - 7'(MONDAY));
        from_wed = mod7_7(7'(w) + 7'd7 - 7'(WEDNESDAY));

        s4_fy_next = s3_y_reg;
        s4_fm_next = 4'd1;
        s4_fd_next = 5'd1;
        unique case (s3_op_reg)
            OP_XMAS_EVE:   begin s4_fm_next = 4'd12; s4_fd_next = 5'd24; end
            OP_XMAS:       begin s4_fm_next = 4'd12; s4_fd_next = 5'd25; end
            OP_MAY_DAY:    begin s4_fm_next = 4'd5;  s4_fd_next = 5'd1;  end
            OP_OCT_3:      begin s4_fm_next = 4'd10; s4_fd_next = 5'd3;  end
            OP_DEC_26:     begin s4_fm_next = 4'd12; s4_fd_next = 5'd26; end
            OP_EPIPHANY:   begin s4_fm_next = 4'd1;  s4_fd_next = 5'd6;  end
            OP_MAR_8:      begin s4_fm_next = 4'd3;  s4_fd_next = 5'd8;  end
            OP_AUG_15:     begin s4_fm_next = 4'd8;  s4_fd_next = 5'd15; end
            OP_SEP_20:     begin s4_fm_next = 4'd9;  s4_fd_next = 5'd20; end
            OP_OCT_31:     begin s4_fm_next = 4'd10; s4_fd_next = 5'd31; end
            OP_NOV_1:      begin s4_fm_next = 4'd11; s4_fd_next = 5'd1;  end
            OP_US_NEW_YEAR:
            begin
                // Saturday Jan 1 falls back to Dec 31 of the previous year
                if (w == SATURDAY)
                begin
                    s4_fy_next = s3_y_reg - 14'd1;
                    s4_fm_next = 4'd12;
                    s4_fd_next = 5'd31;
                end
                else if (w == SUNDAY)
                    s4_fd_next = 5'd2;
            end
            OP_US_INDEP:
            begin
                s4_fm_next = 4'd7;
                s4_fd_next = (w == SATURDAY) ? 5'd3 : ((w == SUNDAY) ? 5'd5 : 5'd4);
            end
            OP_VETERANS:
            begin
                s4_fm_next = 4'd11;
                s4_fd_next = (w == SATURDAY) ? 5'd10 : ((w == SUNDAY) ? 5'd12 : 5'd11);
            end
            OP_US_XMAS:
            begin
                s4_fm_next = 4'd12;
                s4_fd_next = (w == SATURDAY) ? 5'd24 : ((w == SUNDAY) ? 5'd26 : 5'd25);
            end
            OP_MLK:          begin s4_fm_next = 4'd1;  s4_fd_next = 5'd15 + 5'(to_mon); end
            OP_PRESIDENTS:   begin s4_fm_next = 4'd2;  s4_fd_next = 5'd15 + 5'(to_mon); end
            OP_MEMORIAL:     begin s4_fm_next = 4'd5;  s4_fd_next = 5'd31 - 5'(from_mon); end
            OP_LABOR:        begin s4_fm_next = 4'd9;  s4_fd_next = 5'd1 + 5'(to_mon); end
            OP_COLUMBUS:     begin s4_fm_next = 4'd10; s4_fd_next = 5'd8 + 5'(to_mon); end
            OP_THANKSGIVING: begin s4_fm_next = 4'd11; s4_fd_next = 5'd22 + 5'(to_thu); end
            OP_NOV_22_WED:   begin s4_fm_next = 4'd11; s4_fd_next = 5'd22 - 5'(from_wed); end
            default:         begin s4_fm_next = 4'd1;  s4_fd_next = 5'd1; end
        endcase
    end

    // Stage 5: h = hsum mod 30
    always_comb
    begin
        h_prod    = 19'(s4_hsum_reg) * 19'(DIV30_MUL);
        h_diff    = s4_hsum_reg - 10'(h_prod[18:14]) * 10'd30;
        s5_h_next = h_diff[4:0];
    end

    // Stage 6: l
    always_comb
    begin
        s6_l_next = mod7_7(7'd32 + 7'(s5_e_reg) * 7'd2 + 7'(s5_i_reg) * 7'd2
                           - 7'(s5_h_reg) - 7'(s5_k_reg));
    end

    // Stage 7: Easter day index and offset
    always_comb
    begin
        m_sum = 9'(s6_a19_reg) + 9'(s6_h_reg) * 9'd11 + 9'(s6_l_reg) * 9'd22;
        idx_g = 7'(s6_h_reg) + 7'(s6_l_reg) + 7'd21 - ((m_sum >= 9'd451) ? 7'd7 : 7'd0);
        s7_eas_next = 1'b1;
        idx_base    = idx_g;
        unique case (s6_op_reg)
            OP_EASTER:         ofs = OFS_NONE;
            OP_ORTH_JULIAN:    begin ofs = OFS_NONE; idx_base = s6_idxj_reg; end
            OP_ORTH_GREG:      begin ofs = OFS_ORTH; idx_base = s6_idxj_reg; end
            OP_GOOD_FRIDAY:    ofs = OFS_GOOD_FRI;
            OP_EASTER_MON:     ofs = OFS_EAS_MON;
            OP_PENTECOST:      ofs = OFS_PENTECOST;
            OP_PENTECOST_MON:  ofs = OFS_PENT_MON;
            OP_ASCENSION:      ofs = OFS_ASCENSION;
            OP_CORPUS_CHRISTI: ofs = OFS_CORPUS;
            default:           begin ofs = OFS_NONE; s7_eas_next = 1'b0; end
        endcase
        idx_sum     = {1'b0, idx_base} + ofs;
        s7_idx_next = idx_sum[6:0];
    end

    // Stage 8: day index from March 1 to month and day for Easter-based dates; others pass
    always_comb
    begin
        year_out_next  = s7_fy_reg;
        month_out_next = s7_fm_reg;
        day_out_next   = s7_fd_reg;
        if (s7_eas_reg)
        begin
            if (s7_idx_reg < 7'd31)
            begin
                month_out_next = 4'd3;
                day_out_next   = 5'(s7_idx_reg + 7'd1);
            end
            else if (s7_idx_reg < 7'd61)
            begin
                month_out_next = 4'd4;
                day_out_next   = 5'(s7_idx_reg - 7'd30);
            end
            else if (s7_idx_reg < 7'd92)
            begin
                month_out_next = 4'd5;
                day_out_next   = 5'(s7_idx_reg - 7'd60);
            end
            else
            begin
                month_out_next = 4'd6;
                day_out_next   = 5'(s7_idx_reg - 7'd91);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_op_reg  <= s1_op_next;
            s1_y_reg   <= s1_y_next;
            s1_b_reg   <= s1_b_next;
            s1_q19_reg <= s1_q19_next;
            s1_q7_reg  <= s1_q7_next;
            s1_qyy_reg <= s1_qyy_next;
        end
        if (en[1])
        begin
            s2_op_reg  <= s1_op_reg;
            s2_y_reg   <= s1_y_reg;
            s2_b_reg   <= s1_b_reg;
            s2_a19_reg <= s2_a19_next;
            s2_c_reg   <= s2_c_next;
            s2_a7_reg  <= s2_a7_next;
            s2_f_reg   <= s2_f_next;
            s2_s_reg   <= s2_s_next;
        end
        if (en[2])
        begin
            s3_op_reg   <= s2_op_reg;
            s3_y_reg    <= s2_y_reg;
            s3_b_reg    <= s2_b_reg;
            s3_a19_reg  <= s2_a19_reg;
            s3_c_reg    <= s2_c_reg;
            s3_a7_reg   <= s2_a7_reg;
            s3_g_reg    <= s3_g_next;
            s3_jd_reg   <= s3_jd_next;
            s3_wd1_reg  <= s3_wd1_next;
            s3_leap_reg <= s3_leap_next;
        end
        if (en[3])
        begin
            s4_op_reg   <= s3_op_reg;
            s4_fy_reg   <= s4_fy_next;
            s4_fm_reg   <= s4_fm_next;
            s4_fd_reg   <= s4_fd_next;
            s4_hsum_reg <= s4_hsum_next;
            s4_idxj_reg <= s4_idxj_next;
            s4_a19_reg  <= s3_a19_reg;
            s4_c_reg    <= s3_c_reg;
            s4_e_reg    <= s3_b_reg[1:0];
        end
        if (en[4])
        begin
            s5_op_reg   <= s4_op_reg;
            s5_fy_reg   <= s4_fy_reg;
            s5_fm_reg   <= s4_fm_reg;
            s5_fd_reg   <= s4_fd_reg;
            s5_idxj_reg <= s4_idxj_reg;
            s5_a19_reg  <= s4_a19_reg;
            s5_h_reg    <= s5_h_next;
            s5_i_reg    <= s4_c_reg[6:2];
            s5_k_reg    <= s4_c_reg[1:0];
            s5_e_reg    <= s4_e_reg;
        end
        if (en[5])
        begin
            s6_op_reg   <= s5_op_reg;
            s6_fy_reg   <= s5_fy_reg;
            s6_fm_reg   <= s5_fm_reg;
            s6_fd_reg   <= s5_fd_reg;
            s6_idxj_reg <= s5_idxj_reg;
            s6_a19_reg  <= s5_a19_reg;
            s6_h_reg    <= s5_h_reg;
            s6_l_reg    <= s6_l_next;
        end
        if (en[6])
        begin
            s7_eas_reg <= s7_eas_next;
            s7_fy_reg  <= s6_fy_reg;
            s7_fm_reg  <= s6_fm_reg;
            s7_fd_reg  <= s6_fd_reg;
            s7_idx_reg <= s7_idx_next;
        end
        if (en[7])
        begin
            year_out_reg  <= year_out_next;
            month_out_reg <= month_out_next;
            day_out_reg   <= day_out_next;
        end
    end

    assign year_out  = year_out_reg;
    assign month_out = month_out_reg;
    assign day_out   = day_out_reg;

endmodule
